// ===== rtl/core/sst_pkg.sv =====
// Package of the sorted set table: sizes, codes and state type.
`default_nettype none

package sst_pkg;

    // Number of entries in the store.
    localparam int CAPACITY = 256;
    // Bits of an entry index and of an element count.
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    // Width of one stored key.
    localparam int KEY_W = 32;
    // Widths of the result word fields, of the action code and of the whole result word.
    localparam int POS_W = 9;
    localparam int STS_W = 2;
    localparam int ACT_W = 2;
    localparam int OUT_W = 24;

    // Request actions; the unused code behaves as a find.
    typedef enum logic [ACT_W-1:0] {
        ACT_FIND   = 2'd0,
        ACT_ADD    = 2'd1,
        ACT_DELETE = 2'd2
    } t_action;

    // Result status codes.
    typedef enum logic [STS_W-1:0] {
        STS_OK       = 2'd0,
        STS_NOCHANGE = 2'd1,
        STS_FULL     = 2'd2
    } t_status;

    // Sequencer states of the core.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_COMPARE,
        S_DECIDE,
        S_SHIFT,
        S_INSERT,
        S_RESULT
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/core/sst_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module sst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sorted_set_table_core.sv =====
// Sorted set table: ordered set of signed keys with find, add and delete.
// Steps: accept the request, run a binary search in which each probe reads an entry and
// compares it, close the window on a miss, decide, move entries with each write trailing
// its read, place an added key and post the word.
// One request at a time: a new request is taken only once the sequencer is idle again.
// Reset clears the count and the sequencer; the store needs no clearing.
`default_nettype none

module sorted_set_table_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Request channel.
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // tdata: value[31:0]
    input  wire logic [31:0] i_s_axis_tdata,
    // tuser: action[1:0]
    input  wire logic [1:0]  i_s_axis_tuser,
    // Result channel.
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // tdata: present[0], position[9:1], status[11:10], count[20:12], zero[23:21]
    output logic [23:0]      o_m_axis_tdata
);

    // Sequencer state.
    sst_pkg::t_state r_state, n_state;

    // Request held for the whole operation.
    logic [sst_pkg::ACT_W-1:0]        r_action, n_action;
    logic signed [sst_pkg::KEY_W-1:0] r_key, n_key;

    // Element count and binary search bounds.
    logic [sst_pkg::CNT_W-1:0] r_count, n_count;
    logic [sst_pkg::CNT_W-1:0] r_low, n_low;
    logic [sst_pkg::CNT_W-1:0] r_high, n_high;
    logic [sst_pkg::CNT_W-1:0] r_mid, n_mid;
    logic [sst_pkg::CNT_W-1:0] w_mid;

    // Search outcome and status of the request.
    logic                      r_hit, n_hit;
    logic [sst_pkg::CNT_W-1:0] r_pos, n_pos;
    sst_pkg::t_status          r_status, n_status;

    // Entry move: walking index and the write that trails each read.
    logic [sst_pkg::CNT_W-1:0] r_j, n_j;
    logic                      r_wr_vld, n_wr_vld;
    logic [sst_pkg::IDX_W-1:0] r_wr_addr, n_wr_addr;
    logic                      w_more;

    // Output register.
    logic        r_out_vld, n_out_vld;
    logic [23:0] r_out_data, n_out_data;
    logic        w_out_free;

    // Memory port signals.
    logic                             w_wr_en;
    logic [sst_pkg::IDX_W-1:0]        w_wr_addr;
    logic [sst_pkg::KEY_W-1:0]        w_wr_data;
    logic                             w_rd_en;
    logic [sst_pkg::IDX_W-1:0]        w_rd_addr;
    logic [sst_pkg::KEY_W-1:0]        w_rd_data;
    logic signed [sst_pkg::KEY_W-1:0] w_entry;

    logic w_accept;
    logic w_is_add;

    sst_ram #(
        .WIDTH(sst_pkg::KEY_W),
        .DEPTH(sst_pkg::CAPACITY)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(w_wr_addr),
        .i_wr_data(w_wr_data),
        .i_rd_en  (w_rd_en),
        .i_rd_addr(w_rd_addr),
        .o_rd_data(w_rd_data)
    );

    assign w_entry  = $signed(w_rd_data);
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_is_add = (r_action == sst_pkg::ACT_ADD);

    // Midpoint of the open search window; it lies below the count while the window is open.
    assign w_mid = r_low + ((r_high - r_low) >> 1);

    // An add moves entries count-1 down to pos up by one slot; a delete moves
    // entries pos+1 up to count-1 down by one slot.
    assign w_more = w_is_add ? (r_j > r_pos)
                             : ((r_j + sst_pkg::CNT_W'(1)) < r_count);

    // The finished word may be posted when the output register is empty or
    // is being emptied in this cycle.
    assign w_out_free = !r_out_vld || i_m_axis_tready;

    assign o_s_axis_tready = (r_state == sst_pkg::S_IDLE);
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sst_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = sst_pkg::S_SEARCH;
                end
            end
            sst_pkg::S_SEARCH: begin
                if (r_low == r_high) begin
                    n_state = sst_pkg::S_DECIDE;
                end else begin
                    n_state = sst_pkg::S_COMPARE;
                end
            end
            sst_pkg::S_COMPARE: begin
                if (r_key < w_entry || w_entry < r_key) begin
                    n_state = sst_pkg::S_SEARCH;
                end else begin
                    n_state = sst_pkg::S_DECIDE;
                end
            end
            sst_pkg::S_DECIDE: begin
                if (w_is_add && !r_hit && r_count < sst_pkg::CNT_W'(sst_pkg::CAPACITY)) begin
                    n_state = sst_pkg::S_SHIFT;
                end else if (r_action == sst_pkg::ACT_DELETE && r_hit) begin
                    n_state = sst_pkg::S_SHIFT;
                end else begin
                    n_state = sst_pkg::S_RESULT;
                end
            end
            sst_pkg::S_SHIFT: begin
                if (!w_more) begin
                    n_state = w_is_add ? sst_pkg::S_INSERT : sst_pkg::S_RESULT;
                end
            end
            sst_pkg::S_INSERT: begin
                n_state = sst_pkg::S_RESULT;
            end
            sst_pkg::S_RESULT: begin
                if (w_out_free) begin
                    n_state = sst_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sst_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath, memory controls and output word.
    always_comb begin
        n_action   = r_action;
        n_key      = r_key;
        n_count    = r_count;
        n_low      = r_low;
        n_high     = r_high;
        n_mid      = r_mid;
        n_hit      = r_hit;
        n_pos      = r_pos;
        n_status   = r_status;
        n_j        = r_j;
        n_wr_vld   = 1'b0;
        n_wr_addr  = r_wr_addr;
        n_out_vld  = r_out_vld && !i_m_axis_tready;
        n_out_data = r_out_data;
        w_rd_en    = 1'b0;
        w_rd_addr  = w_mid[sst_pkg::IDX_W-1:0];
        w_wr_en    = 1'b0;
        w_wr_addr  = r_wr_addr;
        w_wr_data  = w_rd_data;

        unique case (r_state)
            sst_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_action = i_s_axis_tuser;
                    n_key    = $signed(i_s_axis_tdata);
                    n_low    = '0;
                    n_high   = r_count;
                    n_hit    = 1'b0;
                end
            end
            sst_pkg::S_SEARCH: begin
                if (r_low == r_high) begin
                    n_pos = r_low;
                end else begin
                    w_rd_en = 1'b1;
                    n_mid   = w_mid;
                end
            end
            sst_pkg::S_COMPARE: begin
                if (r_key < w_entry) begin
                    n_high = r_mid;
                end else if (w_entry < r_key) begin
                    n_low = r_mid + sst_pkg::CNT_W'(1);
                end else begin
                    n_hit = 1'b1;
                    n_pos = r_mid;
                end
            end
            sst_pkg::S_DECIDE: begin
                priority if (w_is_add) begin
                    if (r_hit) begin
                        n_status = sst_pkg::STS_NOCHANGE;
                    end else if (r_count >= sst_pkg::CNT_W'(sst_pkg::CAPACITY)) begin
                        n_status = sst_pkg::STS_FULL;
                    end else begin
                        n_status = sst_pkg::STS_OK;
                        n_j      = r_count;
                    end
                end else if (r_action == sst_pkg::ACT_DELETE) begin
                    n_status = r_hit ? sst_pkg::STS_OK : sst_pkg::STS_NOCHANGE;
                    n_j      = r_pos;
                end else begin
                    n_status = r_hit ? sst_pkg::STS_OK : sst_pkg::STS_NOCHANGE;
                end
            end
            sst_pkg::S_SHIFT: begin
                // The entry read in the previous cycle lands at its new slot.
                w_wr_en = r_wr_vld;
                if (w_more) begin
                    w_rd_en   = 1'b1;
                    n_wr_vld  = 1'b1;
                    n_wr_addr = r_j[sst_pkg::IDX_W-1:0];
                    if (w_is_add) begin
                        w_rd_addr = r_j[sst_pkg::IDX_W-1:0] - sst_pkg::IDX_W'(1);
                        n_j       = r_j - sst_pkg::CNT_W'(1);
                    end else begin
                        w_rd_addr = r_j[sst_pkg::IDX_W-1:0] + sst_pkg::IDX_W'(1);
                        n_j       = r_j + sst_pkg::CNT_W'(1);
                    end
                end else if (!w_is_add) begin
                    n_count = r_count - sst_pkg::CNT_W'(1);
                end
            end
            sst_pkg::S_INSERT: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_pos[sst_pkg::IDX_W-1:0];
                w_wr_data = r_key;
                n_count   = r_count + sst_pkg::CNT_W'(1);
            end
            sst_pkg::S_RESULT: begin
                if (w_out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_data = {3'b000,
                                  sst_pkg::POS_W'(r_count),
                                  r_status,
                                  sst_pkg::POS_W'(r_pos),
                                  r_hit};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sst_pkg::S_IDLE;
            r_count   <= '0;
            r_wr_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_wr_vld  <= n_wr_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action   <= n_action;
        r_key      <= n_key;
        r_low      <= n_low;
        r_high     <= n_high;
        r_mid      <= n_mid;
        r_hit      <= n_hit;
        r_pos      <= n_pos;
        r_status   <= n_status;
        r_j        <= n_j;
        r_wr_addr  <= n_wr_addr;
        r_out_data <= n_out_data;
    end

endmodule

`default_nettype wire
